@@ src/fgt_pkg.sv @@
// Package for the flow grouping table: item types, stored entry layout,
// scan controller states and fixed constants. No dependencies.
package fgt_pkg;

  localparam logic [3:0] LIMIT_RESET  = 4'd10;
  localparam int unsigned ADDR_W      = 13;
  localparam logic STATUS_STORED      = 1'b0;
  localparam logic STATUS_FULL        = 1'b1;

  typedef struct packed {
    logic [1:0]  pool_select;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
  } in_item_t;

  typedef struct packed {
    logic [5:0] group_index;
    logic [3:0] group_count;
    logic       new_group;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
  } key_t;

  typedef struct packed {
    key_t       key;
    logic [3:0] count;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } scan_state_e;

endpackage

@@ src/fgt_if.sv @@
// Valid/ready channel interfaces for packet items and result items.
// Depends on fgt_pkg for the payload types.
interface fgt_in_if;
  logic              valid;
  logic              ready;
  fgt_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fgt_out_if;
  logic               valid;
  logic               ready;
  fgt_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/flow_grouping_table.sv @@
// On a hit the result follows a scan up to the matching group; on a miss the whole pool is scanned
// and the item is appended, or refused as full; an item for an unknown pool is refused at once.
// One item is handled at a time; a new item is accepted while a result waits
// in the output register.
// Reset clears the pool fill counts and sets the group limit to 10; group store contents
// are undefined until written and need no clearing pass.
module flow_grouping_table #(
  parameter int unsigned GROUPS_PER_POOL = 64,
  parameter int unsigned POOL_COUNT      = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  fgt_in_if.sink     in_i,
  fgt_out_if.source  out_o
);

  logic [3:0]         limit_q;
  logic               out_valid_q;
  fgt_pkg::out_item_t out_item_q;
  logic               res_valid;
  logic               res_ready;
  fgt_pkg::out_item_t res_item;
  fgt_pkg::mem_req_t  mem_req;
  fgt_pkg::entry_t    mem_rdata;

  assign res_ready = !out_valid_q || out_o.ready;

  fgt_scan #(
    .GROUPS_PER_POOL (GROUPS_PER_POOL),
    .POOL_COUNT      (POOL_COUNT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_q),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res_item),
    .res_ready_i (res_ready),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  fgt_group_mem #(
    .DEPTH (POOL_COUNT * GROUPS_PER_POOL)
  ) u_group_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= fgt_pkg::LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_item_q <= res_item;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

@@ src/fgt_group_mem.sv @@
// Group store: one synchronous memory holding each group's key and count.
// One write and one read per cycle, read data registered. Depends on fgt_pkg.
module fgt_group_mem #(
  parameter int unsigned DEPTH = 192
) (
  input  logic              clk_i,
  input  fgt_pkg::mem_req_t req_i,
  output fgt_pkg::entry_t   rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fgt_pkg::entry_t mem [DEPTH];
  fgt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fgt_scan.sv @@
// Scan controller: walks the selected pool's groups through the group store,
// updates the matching group, appends a new one or reports the item as full. Depends on fgt_pkg, fgt_if.
module fgt_scan #(
  parameter int unsigned GROUPS_PER_POOL = 64,
  parameter int unsigned POOL_COUNT      = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           limit_i,
  fgt_in_if.sink               in_i,
  output logic                 res_valid_o,
  output fgt_pkg::out_item_t   res_o,
  input  logic                 res_ready_i,
  output fgt_pkg::mem_req_t    mem_req_o,
  input  fgt_pkg::entry_t      mem_rdata_i
);

  localparam int unsigned PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int unsigned FW = $clog2(GROUPS_PER_POOL + 1);
  localparam int unsigned AW = fgt_pkg::ADDR_W;

  fgt_pkg::scan_state_e state_q, state_d;
  fgt_pkg::key_t        key_q, key_d;
  fgt_pkg::out_item_t   res_q, res_d;
  logic [PW-1:0]        pool_q, pool_d;
  logic [AW-1:0]        base_q, base_d;
  logic [FW-1:0]        cur_fill_q, cur_fill_d;
  logic [FW-1:0]        rd_idx_q, rd_idx_d;
  logic [FW-1:0]        cmp_idx_q, cmp_idx_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [FW-1:0]        fill_q [POOL_COUNT];
  logic                 fill_we;
  logic                 pool_ok;
  logic [PW-1:0]        in_pool;
  logic                 hit;
  logic                 more;
  logic [3:0]           cnt_inc;

  assign in_pool = PW'(in_i.payload.pool_select);
  assign pool_ok = 32'(in_i.payload.pool_select) < POOL_COUNT;
  assign more    = rd_idx_q < cur_fill_q;
  assign cnt_inc = 4'(mem_rdata_i.count + 4'd1);
  assign hit     = rd_pend_q && (mem_rdata_i.key == key_q) && (mem_rdata_i.count < limit_i);

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    res_d      = res_q;
    pool_d     = pool_q;
    base_d     = base_q;
    cur_fill_d = cur_fill_q;
    rd_idx_d   = rd_idx_q;
    cmp_idx_d  = cmp_idx_q;
    rd_pend_d  = 1'b0;
    fill_we    = 1'b0;
    in_i.ready = 1'b0;
    res_valid_o = 1'b0;
    mem_req_o  = '0;
    mem_req_o.rd_addr = AW'(32'(base_q) + 32'(rd_idx_q));
    mem_req_o.wr_data = '{key: key_q, count: 4'd1};
    case (state_q)
      fgt_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          key_d = '{src_ip:   in_i.payload.src_ip,
                    dst_ip:   in_i.payload.dst_ip,
                    sport:    in_i.payload.sport,
                    dport:    in_i.payload.dport,
                    protocol: in_i.payload.protocol};
          pool_d   = in_pool;
          rd_idx_d = '0;
          if (pool_ok) begin
            base_d     = AW'(32'(in_i.payload.pool_select) * GROUPS_PER_POOL);
            cur_fill_d = fill_q[in_pool];
            state_d    = fgt_pkg::ST_SCAN;
          end else begin
            res_d   = '{group_index: '0, group_count: '0, new_group: 1'b0,
                        status: fgt_pkg::STATUS_FULL};
            state_d = fgt_pkg::ST_DONE;
          end
        end
      end
      fgt_pkg::ST_SCAN: begin
        if (hit) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = AW'(32'(base_q) + 32'(cmp_idx_q));
          mem_req_o.wr_data = '{key: key_q, count: cnt_inc};
          res_d   = '{group_index: 6'(cmp_idx_q), group_count: cnt_inc, new_group: 1'b0,
                      status: fgt_pkg::STATUS_STORED};
          state_d = fgt_pkg::ST_DONE;
        end else if (!rd_pend_q && !more) begin
          if (32'(cur_fill_q) >= GROUPS_PER_POOL) begin
            res_d = '{group_index: '0, group_count: '0, new_group: 1'b0,
                      status: fgt_pkg::STATUS_FULL};
          end else begin
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = AW'(32'(base_q) + 32'(cur_fill_q));
            fill_we = 1'b1;
            res_d = '{group_index: 6'(cur_fill_q), group_count: 4'd1, new_group: 1'b1,
                      status: fgt_pkg::STATUS_STORED};
          end
          state_d = fgt_pkg::ST_DONE;
        end else if (more) begin
          mem_req_o.rd_en = 1'b1;
          rd_pend_d = 1'b1;
          cmp_idx_d = rd_idx_q;
          rd_idx_d  = FW'(rd_idx_q + 1'b1);
        end
      end
      fgt_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = fgt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fgt_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fgt_pkg::ST_IDLE;
      rd_pend_q <= 1'b0;
      for (int p = 0; p < POOL_COUNT; p++) begin
        fill_q[p] <= '0;
      end
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
      if (fill_we) begin
        fill_q[pool_q] <= FW'(cur_fill_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    res_q      <= res_d;
    pool_q     <= pool_d;
    base_q     <= base_d;
    cur_fill_q <= cur_fill_d;
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
  end

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> state_q == fgt_pkg::ST_SCAN)
    else $error("group store written outside a scan");

  a_read_below_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.rd_en |-> rd_idx_q < cur_fill_q)
    else $error("group read at or beyond the pool fill");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fgt_pkg::ST_SCAN |-> 32'(cur_fill_q) <= GROUPS_PER_POOL)
    else $error("pool fill exceeds the pool size");

  a_append_bumps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_we |=> fill_q[$past(pool_q)] == FW'($past(cur_fill_q) + 1'b1))
    else $error("pool fill not advanced after an append");

endmodule
